### sv/crc8_word_frame_codec_assert.svh
// Assertion helpers for the word framing codec.
`ifndef CRC8_WORD_FRAME_CODEC_ASSERT_SVH
`define CRC8_WORD_FRAME_CODEC_ASSERT_SVH

// Same-cycle implication, skipped while reset is high.
`define CRC8WFC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("crc8 word frame codec: assertion failed");

// Next-cycle implication, skipped while reset is high.
`define CRC8WFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("crc8 word frame codec: assertion failed");

`endif

### sv/crc8wfc_pkg.sv
`timescale 1ns / 1ps
package crc8wfc_pkg;

  localparam int WORD_BYTES = 2;
  localparam int CFG_INDEX_W = 1;

  localparam logic [7:0] CRC_POLY_RESET = 8'h31;
  localparam logic [7:0] CRC_START_RESET = 8'hFF;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CRC_POLY  = 1'b0,
    REG_CRC_START = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_BYTE    = 2'd0,
    ST_CRC_ERR = 2'd1,
    ST_LEN_ERR = 2'd2,
    ST_OK      = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] data;
    status_t    status;
    logic       last;
  } result_t;

  // One byte through the CRC-8 register, MSB first.
  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b,
                                          input logic [7:0] poly);
    logic [7:0] r;
    r = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (r[7]) begin
        r = {r[6:0], 1'b0} ^ poly;
      end else begin
        r = {r[6:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

### sv/crc8_word_frame_codec.sv
`timescale 1ns / 1ps
// An accepted item is held in the input register; its results load into the result buffer
// once the buffer is empty or is handing out its last result, and are offered from there.
// Items yielding at most one result (decode data bytes) are taken one per cycle while
// m_axis_tready holds; an encoded word or a good group sends its results one at a time.
// Reset: empties both stages, clears group position and discard flag, and restores
// crc_poly to 0x31 and crc_start to 0xFF.
`include "crc8_word_frame_codec_assert.svh"

module crc8_word_frame_codec (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [crc8wfc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]  cfg_data,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] byte_in, [23:8] word_in
  input  logic        s_axis_tuser,   // [0] action
  input  logic        s_axis_tlast,   // last_in
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  output logic        m_axis_tlast    // last_out
);

  // configuration
  logic [7:0] crc_poly;
  logic [7:0] crc_start;

  // input register
  logic        in_valid;
  logic        in_action;
  logic [7:0]  in_byte;
  logic [15:0] in_word;
  logic        in_last;
  logic [7:0]  in_hi_crc;

  // decode state
  logic [1:0] group_pos, group_pos_next;
  logic [7:0] held_bytes [crc8wfc_pkg::WORD_BYTES];
  logic [7:0] running_crc, running_crc_next;
  logic       discarding, discarding_next;
  logic       held_we;

  // result buffer
  crc8wfc_pkg::result_t slot [3];
  crc8wfc_pkg::result_t res [3];
  logic [1:0] cnt;
  logic [1:0] res_cnt;

  logic s_xfer, m_xfer, move;
  logic [7:0] base_crc, upd_crc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_poly  <= crc8wfc_pkg::CRC_POLY_RESET;
      crc_start <= crc8wfc_pkg::CRC_START_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (crc8wfc_pkg::reg_index_t'(cfg_index))
        crc8wfc_pkg::REG_CRC_POLY:  crc_poly  <= cfg_data;
        crc8wfc_pkg::REG_CRC_START: crc_start <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_xfer = s_axis_tvalid && s_axis_tready;
  assign m_xfer = m_axis_tvalid && m_axis_tready;
  // hand the input register over when the buffer is empty or empties this cycle
  assign move = in_valid && ((cnt == 2'd0) || ((cnt == 2'd1) && m_axis_tready));
  assign s_axis_tready = !in_valid || move;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_xfer) begin
      in_valid <= 1'b1;
    end else if (move) begin
      in_valid <= 1'b0;
    end
  end

  // first half of the encode CRC is done at the transfer
  always_ff @(posedge clk) begin
    if (s_xfer) begin
      in_action <= s_axis_tuser;
      in_byte   <= s_axis_tdata[7:0];
      in_word   <= s_axis_tdata[23:8];
      in_last   <= s_axis_tlast;
      in_hi_crc <= crc8wfc_pkg::crc_byte(crc_start, s_axis_tdata[23:16], crc_poly);
    end
  end

  // one CRC step shared by encode low byte and decode data bytes
  always_comb begin
    if (in_action) begin
      base_crc = in_hi_crc;
    end else if (group_pos == 2'd0) begin
      base_crc = crc_start;
    end else begin
      base_crc = running_crc;
    end
    upd_crc = crc8wfc_pkg::crc_byte(base_crc,
                                    in_action ? in_word[7:0] : in_byte, crc_poly);
  end

  always_comb begin
    group_pos_next   = group_pos;
    running_crc_next = running_crc;
    discarding_next  = discarding;
    held_we          = 1'b0;
    res_cnt          = 2'd0;
    for (int i = 0; i < 3; i++) begin
      res[i] = '{data: 8'h00, status: crc8wfc_pkg::ST_BYTE, last: 1'b0};
    end
    if (in_action) begin
      res[0].data = in_word[15:8];
      res[1].data = in_word[7:0];
      res[2].data = upd_crc;
      res[2].last = 1'b1;
      res_cnt     = 2'd3;
    end else if (discarding) begin
      if (in_last) begin
        discarding_next  = 1'b0;
        group_pos_next   = 2'd0;
        running_crc_next = crc_start;
      end
    end else if (!group_pos[1]) begin
      held_we          = 1'b1;
      running_crc_next = upd_crc;
      group_pos_next   = group_pos + 2'd1;
      if (in_last) begin
        res[0].status    = crc8wfc_pkg::ST_LEN_ERR;
        res[0].last      = 1'b1;
        res_cnt          = 2'd1;
        group_pos_next   = 2'd0;
        running_crc_next = crc_start;
      end
    end else begin
      group_pos_next   = 2'd0;
      running_crc_next = crc_start;
      if (in_byte == running_crc) begin
        res[0].data = held_bytes[0];
        res[1].data = held_bytes[1];
        if (in_last) begin
          res[2].status = crc8wfc_pkg::ST_OK;
          res[2].last   = 1'b1;
          res_cnt       = 2'd3;
        end else begin
          res_cnt = 2'd2;
        end
      end else begin
        res[0].status   = crc8wfc_pkg::ST_CRC_ERR;
        res[0].last     = 1'b1;
        res_cnt         = 2'd1;
        discarding_next = !in_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_pos   <= 2'd0;
      running_crc <= crc8wfc_pkg::CRC_START_RESET;
      discarding  <= 1'b0;
    end else if (move) begin
      group_pos   <= group_pos_next;
      running_crc <= running_crc_next;
      discarding  <= discarding_next;
    end
  end

  always_ff @(posedge clk) begin
    if (move && held_we) begin
      held_bytes[group_pos[0]] <= in_byte;
    end
  end

  // result buffer: load a whole item, then shift one result per transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (move) begin
      cnt <= res_cnt;
    end else if (m_xfer) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      slot[0] <= res[0];
      slot[1] <= res[1];
      slot[2] <= res[2];
    end else if (m_xfer) begin
      slot[0] <= slot[1];
      slot[1] <= slot[2];
    end
  end

  assign m_axis_tvalid = (cnt != 2'd0);
  assign m_axis_tdata  = slot[0].data;
  assign m_axis_tuser  = slot[0].status;
  assign m_axis_tlast  = slot[0].last;

  `CRC8WFC_ASSERT_NOW(a_status_zero, clk, rst,
    m_axis_tvalid && (m_axis_tuser != crc8wfc_pkg::ST_BYTE), m_axis_tdata == 8'h00)
  `CRC8WFC_ASSERT_NOW(a_status_last, clk, rst,
    m_axis_tvalid && (m_axis_tuser != crc8wfc_pkg::ST_BYTE), m_axis_tlast)
  `CRC8WFC_ASSERT_NOW(a_discard_pos, clk, rst, discarding, group_pos == 2'd0)
  `CRC8WFC_ASSERT_NOW(a_pos_range, clk, rst, 1'b1, group_pos != 2'd3)
  `CRC8WFC_ASSERT_NEXT(a_hold_item, clk, rst, in_valid && !move, in_valid)

endmodule

### tb/sv/tb_crc8_word_frame_codec.sv
`timescale 1ns / 1ps
module tb_crc8_word_frame_codec;
  import crc8wfc_pkg::*;

  localparam bit ACT_DECODE = 1'b0;
  localparam bit ACT_ENCODE = 1'b1;
  localparam int ITEMS_PER_PHASE = 20;
  localparam logic [7:0] PHASE_POLY [6] = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'h31, 8'h31};
  localparam logic [7:0] PHASE_START [6] = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h5A, 8'hFF};

  class codec_scoreboard;
    logic [7:0] poly;
    logic [7:0] start;
    logic [1:0] group_pos;
    logic [7:0] held [2];
    logic [7:0] run_crc;
    bit discarding;
    result_t expected_results [$];
    int errors;

    function new();
      poly = CRC_POLY_RESET;
      start = CRC_START_RESET;
      held[0] = 8'h00;
      held[1] = 8'h00;
      discarding = 1'b0;
      errors = 0;
      restart_group();
    endfunction

    function void restart_group();
      group_pos = 2'd0;
      run_crc = start;
    endfunction

    function void write_reg(reg_index_t idx, logic [7:0] value);
      case (idx)
        REG_CRC_POLY: poly = value;
        REG_CRC_START: start = value;
        default: ;
      endcase
    endfunction

    // MSB first: fold the byte in, then eight shifts with conditional polynomial
    function logic [7:0] crc_step(logic [7:0] crc, logic [7:0] b);
      logic [7:0] r;
      r = crc ^ b;
      repeat (8) r = (r << 1) ^ (r[7] ? poly : 8'h00);
      return r;
    endfunction

    function void expect_result(logic [7:0] data, status_t st, logic last);
      result_t res;
      res.data = data;
      res.status = st;
      res.last = last;
      expected_results.push_back(res);
    endfunction

    function void note_transfer(bit act, logic [7:0] b, logic [15:0] w, bit last);
      if (act == ACT_ENCODE) begin
        // encoding leaves the decode state alone
        expect_result(w[15:8], ST_BYTE, 1'b0);
        expect_result(w[7:0], ST_BYTE, 1'b0);
        expect_result(crc_step(crc_step(start, w[15:8]), w[7:0]), ST_BYTE, 1'b1);
      end else if (discarding) begin
        if (last) begin
          discarding = 1'b0;
          restart_group();
        end
      end else if (group_pos < WORD_BYTES) begin
        held[group_pos[0]] = b;
        run_crc = crc_step((group_pos == 2'd0) ? start : run_crc, b);
        group_pos++;
        if (last) begin
          expect_result(8'h00, ST_LEN_ERR, 1'b1);
          restart_group();
        end
      end else if (b == run_crc) begin
        expect_result(held[0], ST_BYTE, 1'b0);
        expect_result(held[1], ST_BYTE, 1'b0);
        restart_group();
        if (last) expect_result(8'h00, ST_OK, 1'b1);
      end else begin
        expect_result(8'h00, ST_CRC_ERR, 1'b1);
        restart_group();
        if (!last) discarding = 1'b1;
      end
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t ns: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [7:0] data, logic [1:0] st, logic last);
      result_t want;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte %02h status %0d last %0b",
                                  data, st, last));
        return;
      end
      want = expected_results.pop_front();
      if (data !== want.data)
        report_mismatch($sformatf("byte %02h, want %02h", data, want.data));
      if (st !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", st, want.status));
      if (last !== want.last)
        report_mismatch($sformatf("last %0b, want %0b", last, want.last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [7:0] cfg_data = 8'h00;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [23:0] s_axis_tdata = 24'h0;   // [7:0] byte_in, [23:8] word_in
  logic s_axis_tuser = 1'b0;           // [0] action
  logic s_axis_tlast = 1'b0;           // last_in
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;            // [7:0] out_byte
  logic [1:0] m_axis_tuser;            // [1:0] status
  logic m_axis_tlast;                  // last_out

  codec_scoreboard sb;
  bit quiet = 1'b0;
  int stall_left = 0;
  int items_sent = 0;

  crc8_word_frame_codec uut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int pick_gap();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 30);
  endfunction

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Fields the block ignores for this action still get random values.
  task automatic send_item(bit act, logic [7:0] b, logic [15:0] w, bit last);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    if (act == ACT_ENCODE) begin
      s_axis_tdata <= {w, 8'($urandom)};
      s_axis_tlast <= 1'($urandom);
    end else begin
      s_axis_tdata <= {16'($urandom), b};
      s_axis_tlast <= last;
    end
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
    sb.note_transfer(act, b, w, last);
    gap = (quiet || $urandom_range(0, 3) != 0) ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Two data bytes and a CRC byte; the CRC is the predicted running value, corrupted if asked.
  task automatic send_group(logic [15:0] w, bit last, bit corrupt, bit mix);
    send_item(ACT_DECODE, w[15:8], 16'h0, 1'b0);
    if (mix && $urandom_range(0, 7) == 0) send_item(ACT_ENCODE, 8'h00, rand_word(), 1'b0);
    send_item(ACT_DECODE, w[7:0], 16'h0, 1'b0);
    if (mix && $urandom_range(0, 7) == 0) send_item(ACT_ENCODE, 8'h00, rand_word(), 1'b0);
    send_item(ACT_DECODE, corrupt ? (sb.run_crc ^ 8'($urandom_range(1, 255))) : sb.run_crc,
              16'h0, last);
  endtask

  task automatic write_cfg(reg_index_t idx, logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  task automatic set_config(logic [7:0] poly, logic [7:0] start);
    write_cfg(REG_CRC_POLY, poly);
    write_cfg(REG_CRC_START, start);
    cfg_valid <= 1'b0;
  endtask

  // Drop valid, drain all expected results, then let the pipeline settle.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    if (quiet) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 7) == 0) stall_left <= pick_gap();
    end
  end

  initial begin
    int r;
    int n;
    int p;
    int phase_end;
    bit last;
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // encode extremes
    send_item(ACT_ENCODE, 8'h00, 16'h0000, 1'b0);
    send_item(ACT_ENCODE, 8'h00, 16'hFFFF, 1'b0);
    send_item(ACT_ENCODE, 8'h00, 16'h1234, 1'b0);
    // two good groups, read ends ok
    send_group(16'hFF00, 1'b0, 1'b0, 1'b0);
    send_group(16'h00FF, 1'b1, 1'b0, 1'b0);
    // CRC error on the last byte of a read
    send_group(16'hA55A, 1'b1, 1'b1, 1'b0);
    // CRC error mid-read: drop bytes up to last
    send_group(16'h5AA5, 1'b0, 1'b1, 1'b0);
    send_item(ACT_DECODE, 8'hFF, 16'h0, 1'b0);
    send_item(ACT_DECODE, 8'h00, 16'h0, 1'b1);
    // read ends on first and on second data byte
    send_item(ACT_DECODE, 8'h81, 16'h0, 1'b1);
    send_item(ACT_DECODE, 8'h7E, 16'h0, 1'b0);
    send_item(ACT_DECODE, 8'hC3, 16'h0, 1'b1);
    // encode interleaved inside a group
    send_item(ACT_DECODE, 8'h12, 16'h0, 1'b0);
    send_item(ACT_ENCODE, 8'h00, 16'hBEEF, 1'b0);
    send_item(ACT_DECODE, 8'h34, 16'h0, 1'b0);
    send_item(ACT_DECODE, sb.run_crc, 16'h0, 1'b1);
    // registers change between the two data bytes of a group
    send_item(ACT_DECODE, 8'hC0, 16'h0, 1'b0);
    wait_idle();
    set_config(8'h07, 8'h00);
    send_item(ACT_DECODE, 8'hDE, 16'h0, 1'b0);
    send_item(ACT_DECODE, sb.run_crc, 16'h0, 1'b1);

    for (p = 0; p < 6; p++) begin
      wait_idle();
      set_config((p == 4) ? 8'($urandom) : PHASE_POLY[p],
                 (p == 4) ? 8'($urandom) : PHASE_START[p]);
      quiet <= (p == 2);
      phase_end = items_sent + ITEMS_PER_PHASE;
      while (items_sent < phase_end) begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          n = $urandom_range(1, 3);
          for (int k = 0; k < n; k++) send_group(rand_word(), k == n - 1, 1'b0, 1'b1);
        end else if (r < 70) begin
          send_item(ACT_ENCODE, 8'h00, rand_word(), 1'b0);
        end else if (r < 80) begin
          last = 1'($urandom);
          send_group(rand_word(), last, 1'b1, 1'b1);
          if (!last) begin
            repeat ($urandom_range(0, 4)) send_item(ACT_DECODE, 8'($urandom), 16'h0, 1'b0);
            send_item(ACT_DECODE, 8'($urandom), 16'h0, 1'b1);
          end
        end else if (r < 90) begin
          repeat ($urandom_range(0, 1)) send_group(rand_word(), 1'b0, 1'b0, 1'b1);
          if ($urandom_range(0, 1)) send_item(ACT_DECODE, 8'($urandom), 16'h0, 1'b0);
          send_item(ACT_DECODE, 8'($urandom), 16'h0, 1'b1);
        end else begin
          // noise, then a last-flagged byte to bring the group back to its start
          n = $urandom_range(1, 6);
          repeat (n) send_item(ACT_DECODE, 8'($urandom), 16'h0, $urandom_range(0, 3) == 0);
          send_item(ACT_DECODE, 8'($urandom), 16'h0, 1'b1);
        end
      end
    end

    wait_idle();
    if (sb.errors == 0 && sb.expected_results.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
